[src/shmm_pkg.sv]
`default_nettype none

package shmm_pkg;

  localparam int HISTORY_DEPTH  = 128;
  localparam int SAMPLE_W       = 10;
  localparam int CENTI_W        = 13;
  localparam int COUNT_W        = 8;
  localparam int FULL_SCALE_IN  = 1023;
  localparam int FULL_SCALE_OUT = 7000;

  // 1023 is one below a power of two, so x/1023 ~ (x + x/1024) / 1024
  localparam int RECIP_SH = $clog2(FULL_SCALE_IN + 1);

  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = $clog2(HISTORY_DEPTH * FULL_SCALE_OUT + 1);
  localparam int PROD_W = $clog2(((2 ** SAMPLE_W) - 1) * FULL_SCALE_OUT + 1);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CENTI_W-1:0]  centi_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [FILL_W-1:0]   fill_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic shift;
    logic rotate;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[src/shmm_cell.sv]
`default_nettype none

module shmm_cell (
  input  logic                clk,
  input  logic                rst,
  input  shmm_pkg::cell_ctrl_t ctrl,
  input  shmm_pkg::centi_t    shift_in,
  input  shmm_pkg::centi_t    rot_in,
  output shmm_pkg::centi_t    value
);
  import shmm_pkg::*;

  // shift pushes toward the old end, rotate walks the ring toward cell 0
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (ctrl.shift) begin
      value <= shift_in;
    end else if (ctrl.rotate) begin
      value <= rot_in;
    end
  end

endmodule

`default_nettype wire

[src/shmm_div.sv]
`default_nettype none

module shmm_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  shmm_pkg::sum_t   dividend,
  input  shmm_pkg::fill_t  divisor,
  output logic             done,
  output shmm_pkg::sum_t   quotient
);
  import shmm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              running;
  logic [STEP_W-1:0] steps;
  fill_t             rem;
  fill_t             dsr;
  logic [FILL_W:0]   trial;
  logic [FILL_W:0]   diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quotient[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= STEP_W'(SUM_W);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (running) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
    end
  end

endmodule

`default_nettype wire

[src/sensor_history_min_max_mean_core.sv]
`default_nettype none

// channel   signals                               dir  role
// in        in_valid in_ready adc_sample          in   raw converter word
// out       out_valid out_ready *_centi stored_c  out  one result word per input word
// cfg       cfg_valid cfg_ready average_count     in   mean length, always ready
//
// each input word passes through S_MUL, S_EST, S_FIX, S_INS, S_ROT, S_DIVST and S_DIV
// before its result word leaves, and the next input word is taken only after that:
// S_MUL to S_INS scale and insert, the cell ring then rotates once around all
// HISTORY_DEPTH cells to sum and find the oldest entry, then a bit-serial
// divider works out the mean, with S_DIVST to start it and S_DIV to load the output once it is free.
// reset clears the ring at once.
// a waiting result in the output register does not block the next input word.

module sensor_history_min_max_mean_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  shmm_pkg::sample_t adc_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output shmm_pkg::centi_t  temperature_centi,
  output shmm_pkg::centi_t  mean_centi,
  output shmm_pkg::centi_t  maximum_centi,
  output shmm_pkg::centi_t  minimum_centi,
  output shmm_pkg::centi_t  oldest_centi,
  output shmm_pkg::count_t  stored_count,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  shmm_pkg::count_t  average_count
);
  import shmm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_EST   = 3'd2;
  localparam logic [2:0] S_FIX   = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_ROT   = 3'd5;
  localparam logic [2:0] S_DIVST = 3'd6;
  localparam logic [2:0] S_DIV   = 3'd7;

  logic [2:0]                state;
  logic                      out_pend;
  count_t                    avg_reg;
  fill_t                     avg_n;
  sample_t                   sample_r;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W:0]           est_sum;
  logic [PROD_W-RECIP_SH:0]  q_est;
  logic [PROD_W:0]           rem_fix;
  centi_t                    temp_r;
  centi_t                    max_r;
  centi_t                    min_r;
  centi_t                    oldest_r;
  centi_t                    mean_r;
  fill_t                     fill;
  idx_t                      k;
  sum_t                      sum;
  cell_ctrl_t                cell_ctrl;
  centi_t                    cell_val [HISTORY_DEPTH];
  logic                      div_done;
  sum_t                      div_q;
  logic                      in_acc;
  logic                      out_load;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // average count saturates at the history depth
  always_comb begin
    if (32'(avg_reg) > HISTORY_DEPTH) begin
      avg_n = FILL_W'(HISTORY_DEPTH);
    end else begin
      avg_n = FILL_W'(avg_reg);
    end
  end

  assign est_sum = {1'b0, prod} + (PROD_W+1)'(prod >> RECIP_SH);
  assign rem_fix = {1'b0, prod} - {q_est, {RECIP_SH{1'b0}}} + (PROD_W+1)'(q_est);

  assign cell_ctrl.shift  = (state == S_INS);
  assign cell_ctrl.rotate = (state == S_ROT);

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      shmm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .shift_in (temp_r),
        .rot_in   (cell_val[(i + 1) % HISTORY_DEPTH]),
        .value    (cell_val[i])
      );
    end else begin : g_body
      shmm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (cell_ctrl),
        .shift_in (cell_val[i-1]),
        .rot_in   (cell_val[(i + 1) % HISTORY_DEPTH]),
        .value    (cell_val[i])
      );
    end
  end

  shmm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIVST),
    .dividend (sum),
    .divisor  (avg_n),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_load = (state == S_DIV) && out_pend && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      out_pend  <= 1'b0;
      avg_reg   <= count_t'(1);
      fill      <= '0;
      max_r     <= '0;
      min_r     <= centi_t'(FULL_SCALE_OUT);
      k         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        avg_reg <= average_count;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_MUL;
          end
        end
        S_MUL:   state <= S_EST;
        S_EST:   state <= S_FIX;
        S_FIX:   state <= S_INS;
        S_INS: begin
          if (fill < FILL_W'(HISTORY_DEPTH)) begin
            fill <= fill + 1'b1;
          end
          if (temp_r > max_r) begin
            max_r <= temp_r;
          end
          if (temp_r < min_r) begin
            min_r <= temp_r;
          end
          k     <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          k <= k + 1'b1;
          if (k == IDX_W'(HISTORY_DEPTH - 1)) begin
            state <= S_DIVST;
          end
        end
        S_DIVST: state <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            out_pend <= 1'b1;
          end
          if (out_load) begin
            out_valid <= 1'b1;
            out_pend  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= adc_sample;
    end
    if (state == S_MUL) begin
      prod <= PROD_W'(sample_r) * PROD_W'(FULL_SCALE_OUT);
    end
    if (state == S_EST) begin
      q_est <= est_sum[PROD_W:RECIP_SH];
    end
    // estimate is low by at most one
    if (state == S_FIX) begin
      if (rem_fix >= (PROD_W+1)'(FULL_SCALE_IN)) begin
        temp_r <= CENTI_W'(q_est + 1'b1);
      end else begin
        temp_r <= CENTI_W'(q_est);
      end
    end
    if (state == S_INS) begin
      sum <= '0;
    end
    // cell 0 holds history entry k during the rotation
    if (state == S_ROT) begin
      if (FILL_W'(k) < avg_n) begin
        sum <= sum + SUM_W'(cell_val[0]);
      end
      if (FILL_W'(k) == fill - 1'b1) begin
        oldest_r <= cell_val[0];
      end
    end
    if (state == S_DIV && div_done) begin
      mean_r <= (avg_n == '0) ? '0 : CENTI_W'(div_q);
    end
    if (out_load) begin
      temperature_centi <= temp_r;
      mean_centi        <= mean_r;
      maximum_centi     <= max_r;
      minimum_centi     <= min_r;
      oldest_centi      <= oldest_r;
      stored_count      <= COUNT_W'(fill);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (fill != '0) |-> (min_r <= max_r))
    else $error("running minimum above running maximum");

  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (mean_r <= centi_t'(FULL_SCALE_OUT)))
    else $error("mean out of range");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_MUL))
    else $error("accepted word did not start processing");

endmodule

`default_nettype wire
